@@ rtl/lht_pkg.sv @@
// shared types and constants for the landmark hop table
package lht_pkg;

  localparam int POS_W = 32;
  localparam int HOP_W = 7;
  localparam int CNT_W = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int Q_DEPTH = 2;
  localparam int Q_AW = $clog2(Q_DEPTH);
  localparam int Q_CW = $clog2(Q_DEPTH + 1);

  localparam logic [HOP_W-1:0] HOP_DROP = 7'h7F;

  localparam logic [1:0] MODE_BCAST = 2'd0;
  localparam logic [1:0] MODE_CORR  = 2'd1;
  localparam logic [1:0] MODE_INIT  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LANDMARK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_X    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_Y    = 2'd2;

  typedef enum logic [1:0] {
    KIND_BCAST,
    KIND_CORR,
    KIND_INIT,
    KIND_NOP
  } kind_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_CMP,
    B_FIN
  } back_state_t;

  typedef struct packed {
    logic [1:0]              mode;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [HOP_W-1:0]        hop_count;
    logic signed [POS_W-1:0] correction_value;
    logic                    solve_in_progress;
  } in_item_t;

  typedef struct packed {
    logic                    relay_valid;
    logic signed [POS_W-1:0] relay_x;
    logic signed [POS_W-1:0] relay_y;
    logic [HOP_W-1:0]        relay_hops;
    logic [CNT_W-1:0]        entry_count;
    logic                    table_full;
    logic                    request_solve;
    logic                    request_correction;
    logic signed [POS_W-1:0] correction_held;
  } out_item_t;

  typedef struct packed {
    kind_t                   kind;
    logic                    drop;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [HOP_W-1:0]        hops_inc;
    logic signed [POS_W-1:0] correction_value;
    logic                    solve_in_progress;
  } work_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [HOP_W-1:0]        hops;
  } entry_t;

  typedef struct packed {
    logic                    landmark;
    logic signed [POS_W-1:0] own_x;
    logic signed [POS_W-1:0] own_y;
  } cfg_t;

endpackage

@@ rtl/landmark_hop_table_top.sv @@
// top level of the landmark hop table
//
// channel  direction  handshake              payload
// in       input      start / busy           in_data   (lht_pkg::in_item_t)
// out      output     out_valid strobe       out_data  (lht_pkg::out_item_t)
// cfg      input      cfg_we, cfg_index      cfg_wdata (32 bits)
//
// init, correction, dropped or unmatched-on-empty items: B_IDLE, B_FIN, out register
// broadcasts scan the table one entry per B_READ/B_CMP pair, up to a hit or the end
// the two-entry work queue takes new commands while the table engine is scanning
// synchronous active-low reset empties the table, the queue and the stored correction
// results are one-cycle strobes; the receiver cannot stall them
module landmark_hop_table_top #(
  parameter int TABLE_ENTRIES = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  lht_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  output lht_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [lht_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lht_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  lht_pkg::cfg_t  cfg_r;
  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;
  lht_pkg::work_t q_wdata;
  lht_pkg::work_t q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        lht_pkg::CFG_LANDMARK: cfg_r.landmark <= cfg_wdata[0];
        lht_pkg::CFG_OWN_X:    cfg_r.own_x    <= cfg_wdata;
        lht_pkg::CFG_OWN_Y:    cfg_r.own_y    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  lht_front u_front (
    .start   (start),
    .in_data (in_data),
    .q_full  (q_full),
    .busy    (busy),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  lht_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  lht_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

@@ rtl/lht_front.sv @@
// front end: accepts commands and classifies them into work items
module lht_front (
  input  logic              start,
  input  lht_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              busy,
  output logic              q_push,
  output lht_pkg::work_t    q_wdata
);

  assign busy   = q_full;
  assign q_push = start & ~q_full;

  always_comb begin
    case (in_data.mode)
      lht_pkg::MODE_BCAST: q_wdata.kind = lht_pkg::KIND_BCAST;
      lht_pkg::MODE_CORR:  q_wdata.kind = lht_pkg::KIND_CORR;
      lht_pkg::MODE_INIT:  q_wdata.kind = lht_pkg::KIND_INIT;
      default:             q_wdata.kind = lht_pkg::KIND_NOP;
    endcase
    q_wdata.drop              = (in_data.hop_count == lht_pkg::HOP_DROP);
    q_wdata.pos_x             = in_data.pos_x;
    q_wdata.pos_y             = in_data.pos_y;
    q_wdata.hops_inc          = in_data.hop_count + lht_pkg::HOP_W'(1);
    q_wdata.correction_value  = in_data.correction_value;
    q_wdata.solve_in_progress = in_data.solve_in_progress;
  end

endmodule

@@ rtl/lht_fifo.sv @@
// short work queue between front end and table engine
module lht_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lht_pkg::work_t wdata,
  input  logic           pop,
  output lht_pkg::work_t rdata,
  output logic           full,
  output logic           empty
);

  lht_pkg::work_t                  slot_r [lht_pkg::Q_DEPTH];
  logic [lht_pkg::Q_AW-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [lht_pkg::Q_AW-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [lht_pkg::Q_CW-1:0]        cnt_r, cnt_nxt;

  assign full  = (cnt_r == lht_pkg::Q_CW'(lht_pkg::Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == lht_pkg::Q_AW'(lht_pkg::Q_DEPTH - 1)) ? '0
                   : wr_ptr_r + lht_pkg::Q_AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == lht_pkg::Q_AW'(lht_pkg::Q_DEPTH - 1)) ? '0
                   : rd_ptr_r + lht_pkg::Q_AW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + lht_pkg::Q_CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - lht_pkg::Q_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ rtl/lht_back.sv @@
// table engine: scans the landmark table, updates it and issues results
module lht_back #(
  parameter int TABLE_ENTRIES = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lht_pkg::cfg_t      cfg,
  input  logic               q_empty,
  input  lht_pkg::work_t     q_data,
  output logic               q_pop,
  output logic               out_valid,
  output lht_pkg::out_item_t out_data
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [lht_pkg::CNT_W-1:0] FULL_CNT = lht_pkg::CNT_W'(TABLE_ENTRIES);

  lht_pkg::back_state_t        state_r, state_nxt;
  lht_pkg::work_t              cur_r;
  logic [IDX_W-1:0]            idx_r, idx_nxt;
  logic                        found_r, found_nxt;
  logic [lht_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic signed [lht_pkg::POS_W-1:0] corr_r, corr_nxt;
  lht_pkg::entry_t             mem [TABLE_ENTRIES];
  lht_pkg::entry_t             rdata_r;
  logic                        mem_we;
  logic [IDX_W-1:0]            mem_waddr;
  lht_pkg::entry_t             mem_wdata;
  logic                        out_valid_r, out_valid_nxt;
  lht_pkg::out_item_t          out_data_r, out_data_nxt;
  logic                        scan_start;
  logic                        hit;
  logic                        last;
  logic                        full_nxt;

  assign scan_start = (q_data.kind == lht_pkg::KIND_BCAST) && !q_data.drop && (count_r != '0);
  assign hit        = (rdata_r.x == cur_r.pos_x) && (rdata_r.y == cur_r.pos_y);
  assign last       = (lht_pkg::CNT_W'(idx_r) + lht_pkg::CNT_W'(1)) == count_r;
  assign full_nxt   = (count_nxt == FULL_CNT);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lht_pkg::B_IDLE: begin
        if (!q_empty) begin
          state_nxt = scan_start ? lht_pkg::B_READ : lht_pkg::B_FIN;
        end
      end
      lht_pkg::B_READ: state_nxt = lht_pkg::B_CMP;
      lht_pkg::B_CMP: begin
        if (hit || last) begin
          state_nxt = lht_pkg::B_FIN;
        end else begin
          state_nxt = lht_pkg::B_READ;
        end
      end
      lht_pkg::B_FIN: state_nxt = lht_pkg::B_IDLE;
      default:        state_nxt = lht_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_pop         = 1'b0;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    count_nxt     = count_r;
    corr_nxt      = corr_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = {cur_r.pos_x, cur_r.pos_y, cur_r.hops_inc};
    out_valid_nxt = 1'b0;
    out_data_nxt  = '0;
    case (state_r)
      lht_pkg::B_IDLE: begin
        q_pop     = !q_empty;
        idx_nxt   = '0;
        found_nxt = 1'b0;
      end
      lht_pkg::B_CMP: begin
        if (hit) begin
          found_nxt = 1'b1;
        end else if (!last) begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      lht_pkg::B_FIN: begin
        case (cur_r.kind)
          lht_pkg::KIND_INIT: begin
            corr_nxt = '0;
            if (cfg.landmark) begin
              mem_we    = 1'b1;
              mem_waddr = '0;
              mem_wdata = {cfg.own_x, cfg.own_y, lht_pkg::HOP_W'(0)};
              count_nxt = lht_pkg::CNT_W'(1);
            end else begin
              count_nxt = '0;
            end
          end
          lht_pkg::KIND_CORR: begin
            if (corr_r == '0) begin
              corr_nxt = cur_r.correction_value;
            end
          end
          lht_pkg::KIND_BCAST: begin
            if (!cur_r.drop) begin
              if (!found_r) begin
                if (count_r < FULL_CNT) begin
                  mem_we    = 1'b1;
                  mem_waddr = count_r[IDX_W-1:0];
                  count_nxt = count_r + lht_pkg::CNT_W'(1);
                end
              end else if (cur_r.hops_inc <= rdata_r.hops) begin
                mem_we                  = 1'b1;
                out_data_nxt.relay_valid = 1'b1;
                out_data_nxt.relay_x     = cur_r.pos_x;
                out_data_nxt.relay_y     = cur_r.pos_y;
                out_data_nxt.relay_hops  = cur_r.hops_inc;
              end
            end
            if (full_nxt) begin
              if (!cfg.landmark && !cur_r.solve_in_progress && corr_r != '0) begin
                out_data_nxt.request_solve = 1'b1;
              end else if (cfg.landmark && corr_r == '0) begin
                out_data_nxt.request_correction = 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
        out_data_nxt.entry_count     = count_nxt;
        out_data_nxt.table_full      = full_nxt;
        out_data_nxt.correction_held = corr_nxt;
        out_valid_nxt                = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lht_pkg::B_IDLE;
      idx_r       <= '0;
      found_r     <= 1'b0;
      count_r     <= '0;
      corr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      found_r     <= found_nxt;
      count_r     <= count_nxt;
      corr_r      <= corr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[idx_r];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/lht_checker.sv @@
// port-level checks for the landmark hop table
module lht_checker #(
  parameter int TABLE_ENTRIES = 8
) (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input lht_pkg::out_item_t out_data
);

  localparam logic [lht_pkg::CNT_W-1:0] FULL_CNT = lht_pkg::CNT_W'(TABLE_ENTRIES);

  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.table_full == (out_data.entry_count == FULL_CNT)))
    else $error("table_full disagrees with entry_count");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.entry_count <= FULL_CNT))
    else $error("entry_count above table size");

  a_req_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.request_solve && out_data.request_correction))
    else $error("both requests raised");

  a_relay_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.relay_valid) |->
      (out_data.relay_x == '0 && out_data.relay_y == '0 && out_data.relay_hops == '0))
    else $error("relay fields set without relay");

  a_relay_hops: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.relay_valid) |-> (out_data.relay_hops != '0))
    else $error("relay with zero hops");

endmodule

bind landmark_hop_table_top lht_checker #(
  .TABLE_ENTRIES (TABLE_ENTRIES)
) u_lht_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_data  (out_data)
);
